FILE: hw/rtl/dmdp_pkg.sv
`default_nettype none

package dmdp_pkg;

  // Fixed field widths.
  localparam int WORD_W  = 64;
  localparam int ROW_W   = 32;
  localparam int INDEX_W = 10;
  localparam int COLS_W  = 11;
  localparam int CFG_W   = 3;

  // Width used for column compares; holds any column count up to 65536.
  localparam int CNT_W = 17;

  // Step counter of the shared modular unit.
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] MUL_LAST      = 7'd4;
  localparam logic [STEP_W-1:0] STEPS_PRODUCT = 7'd127;
  localparam logic [STEP_W-1:0] STEPS_REDUCE  = 7'd63;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ELEMENT = 1'b1;

  typedef enum logic [CFG_W-1:0] {
    REG_PRIME_ONE   = 3'd0,
    REG_PRIME_TWO   = 3'd1,
    REG_INVERSE_ONE = 3'd2,
    REG_INVERSE_TWO = 3'd3,
    REG_COLUMNS     = 3'd4
  } dmdp_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P1_GO,
    S_P1_WAIT,
    S_P2_GO,
    S_P2_WAIT,
    S_R1_GO,
    S_R1_WAIT,
    S_R2_GO,
    S_R2_WAIT,
    S_EMIT
  } dmdp_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_RED,
    U_DONE
  } dmdp_ustate_t;

  // Request to the shared modular unit.
  typedef struct packed {
    logic start;
    logic reduce_only;
  } dmdp_req_t;

  // Status from the shared modular unit.
  typedef struct packed {
    logic busy;
    logic done;
  } dmdp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmdp_intf.sv
`default_nettype none

interface dmdp_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [9:0]  entry_index;
  logic [63:0] word_a;
  logic [63:0] word_b;

  modport source (output valid, op, entry_index, word_a, word_b, input ready);
  modport sink   (input valid, op, entry_index, word_a, word_b, output ready);
endinterface

interface dmdp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_number;
  logic [63:0] dot_one;
  logic [63:0] dot_two;

  modport source (output valid, row_number, dot_one, dot_two, input ready);
  modport sink   (input valid, row_number, dot_one, dot_two, output ready);
endinterface

interface dmdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dmdp_ram.sv
`default_nettype none

module dmdp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dmdp_modunit.sv
`default_nettype none

// Shared modular unit. A product runs four 32x32 partial products into a
// 128-bit register, then reduces it one bit per cycle by shift and
// conditional subtract. A plain reduction skips the multiply and runs 64
// steps on the upper half of the shift register.
module dmdp_modunit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dmdp_pkg::dmdp_req_t  req,
  input  wire logic [63:0]          a,
  input  wire logic [63:0]          b,
  input  wire logic [63:0]          p,
  output logic      [63:0]          result,
  output dmdp_pkg::dmdp_stat_t      stat
);

  dmdp_pkg::dmdp_ustate_t state, state_next;

  logic [63:0]  opa;
  logic [63:0]  opb;
  logic [63:0]  pmod;
  logic [127:0] prod;
  logic [63:0]  pp;
  logic [dmdp_pkg::STEP_W-1:0] cnt;
  logic [63:0]  r;

  logic [31:0]  ma;
  logic [31:0]  mb;
  logic [63:0]  mfull;
  logic [127:0] pp_shifted;
  logic [63:0]  rs;
  logic [63:0]  r_next;

  // Operand halves for the partial product selected by the step count.
  always_comb begin
    unique case (cnt[1:0])
      2'd0: begin ma = opa[31:0];  mb = opb[31:0];  end
      2'd1: begin ma = opa[31:0];  mb = opb[63:32]; end
      2'd2: begin ma = opa[63:32]; mb = opb[31:0];  end
      default: begin ma = opa[63:32]; mb = opb[63:32]; end
    endcase
  end

  assign mfull = ma * mb;

  // The registered partial product is one step behind the count.
  always_comb begin
    unique case (cnt[2:0])
      3'd1:       pp_shifted = {64'd0, pp};
      3'd2, 3'd3: pp_shifted = {32'd0, pp, 32'd0};
      3'd4:       pp_shifted = {pp, 64'd0};
      default:    pp_shifted = '0;
    endcase
  end

  // One restoring step: a carry out of the shift forces the subtract.
  always_comb begin
    rs = {r[62:0], prod[127]};
    if (r[63] || rs >= pmod) begin
      r_next = rs - pmod;
    end else begin
      r_next = rs;
    end
  end

  assign result = (pmod < 64'd2) ? 64'd0 : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmdp_pkg::U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat.busy  = (state != dmdp_pkg::U_IDLE);
    stat.done  = (state == dmdp_pkg::U_DONE);
    unique case (state)
      dmdp_pkg::U_IDLE: begin
        if (req.start) begin
          state_next = req.reduce_only ? dmdp_pkg::U_RED : dmdp_pkg::U_MUL;
        end
      end
      dmdp_pkg::U_MUL: begin
        if (cnt == dmdp_pkg::MUL_LAST) begin
          state_next = dmdp_pkg::U_RED;
        end
      end
      dmdp_pkg::U_RED: begin
        if (cnt == '0) begin
          state_next = dmdp_pkg::U_DONE;
        end
      end
      default: begin
        state_next = dmdp_pkg::U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dmdp_pkg::U_IDLE: begin
        if (req.start) begin
          opa  <= a;
          opb  <= b;
          pmod <= p;
          r    <= '0;
          if (req.reduce_only) begin
            prod <= {a, 64'd0};
            cnt  <= dmdp_pkg::STEPS_REDUCE;
          end else begin
            prod <= '0;
            cnt  <= '0;
          end
        end
      end
      dmdp_pkg::U_MUL: begin
        pp   <= mfull;
        prod <= prod + pp_shifted;
        if (cnt == dmdp_pkg::MUL_LAST) begin
          cnt <= dmdp_pkg::STEPS_PRODUCT;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      dmdp_pkg::U_RED: begin
        r    <= r_next;
        prod <= {prod[126:0], 1'b0};
        cnt  <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dual_modular_dot_product_unit.sv
// A matrix element keeps the input not ready after it is taken, until both
// of its products are done; the element that closes a row also waits for
// both reductions and for a free output register. Reset (rst, synchronous,
// active high) clears sums and counters and sets config to its defaults.
`default_nettype none

// Dual modular dot product unit.
//
// Load words (op = 0) write one entry pair of the two challenge stores in
// the cycle they are taken. Element words (op = 1) are multiplied by the
// challenge entries at the current column, modulo prime one and prime two,
// and the residues are added into two 64-bit wrapping sums.
//
// All modular arithmetic runs on one shared unit. Each exact product
// (a * b) mod p runs there as a start, 32x32 partial products accumulated
// into a 128-bit register, 128 single-bit shift and subtract steps, and a
// done state. The final reduction of a sum runs 64 steps. The programmed
// inverses do not enter this datapath; the bit-serial reduction is exact
// for every modulus.
//
// When a row closes, both reduced sums and the row number are placed in an
// output register, so the next word can be taken while the result waits.
module dual_modular_dot_product_unit #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst,
  dmdp_item_if.sink      item,
  dmdp_result_if.source  result,
  dmdp_cfg_if.sink       cfg
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CW = dmdp_pkg::CNT_W;

  // Configuration registers. The inverses are accepted on the port but not
  // kept, since the reduction does not need them.
  logic [63:0] prime_one;
  logic [63:0] prime_two;
  logic [dmdp_pkg::COLS_W-1:0] columns_in_use;

  // Row state.
  logic [63:0]   sum_one;
  logic [63:0]   sum_two;
  logic [AW-1:0] column_counter;
  logic [31:0]   row_counter;
  logic [63:0]   element;
  logic [63:0]   red_one;

  // Output register.
  logic        out_valid;
  logic [31:0] out_row;
  logic [63:0] out_dot_one;
  logic [63:0] out_dot_two;

  dmdp_pkg::dmdp_state_t state, state_next;

  dmdp_pkg::dmdp_req_t  req;
  dmdp_pkg::dmdp_stat_t stat;
  logic [63:0] unit_a;
  logic [63:0] unit_b;
  logic [63:0] unit_p;
  logic [63:0] unit_result;

  logic [63:0] chal_one;
  logic [63:0] chal_two;

  logic          item_take;
  logic          load_take;
  logic [CW-1:0] idx_wide;
  logic          load_ok;
  logic [CW-1:0] cols_in;
  logic [CW-1:0] cols_eff;
  logic [CW-1:0] col_plus;
  logic          row_last;
  logic          emit_now;

  assign item_take = item.valid && item.ready;
  assign load_take = item_take && (item.op == dmdp_pkg::OP_LOAD);

  // A load beyond the store depth is dropped.
  assign idx_wide = CW'(item.entry_index);
  assign load_ok  = idx_wide < CW'(MAX_COLUMNS);

  // A column count of zero means one; counts above the store depth clamp.
  assign cols_in = CW'(columns_in_use);
  always_comb begin
    if (cols_in == '0) begin
      cols_eff = CW'(1);
    end else if (cols_in > CW'(MAX_COLUMNS)) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_in;
    end
  end

  assign col_plus = CW'(column_counter) + CW'(1);
  assign row_last = col_plus >= cols_eff;

  // The output register can be reloaded when it is empty or being drained.
  assign emit_now = (state == dmdp_pkg::S_EMIT) && (!out_valid || result.ready);

  // Challenge stores. The read address is the current column; it only
  // changes between elements, so the registered data is ready by the time
  // the first product starts.
  dmdp_ram #(.WIDTH(64), .DEPTH(MAX_COLUMNS)) u_store_one (
    .clk   (clk),
    .we    (load_take && load_ok),
    .waddr (idx_wide[AW-1:0]),
    .wdata (item.word_a),
    .raddr (column_counter),
    .rdata (chal_one)
  );

  dmdp_ram #(.WIDTH(64), .DEPTH(MAX_COLUMNS)) u_store_two (
    .clk   (clk),
    .we    (load_take && load_ok),
    .waddr (idx_wide[AW-1:0]),
    .wdata (item.word_b),
    .raddr (column_counter),
    .rdata (chal_two)
  );

  dmdp_modunit u_modunit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (unit_a),
    .b      (unit_b),
    .p      (unit_p),
    .result (unit_result),
    .stat   (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmdp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: two products per element, two reductions per finished row.
  always_comb begin
    state_next      = state;
    req.start       = 1'b0;
    req.reduce_only = 1'b0;
    unit_a          = element;
    unit_b          = chal_one;
    unit_p          = prime_one;
    item.ready      = (state == dmdp_pkg::S_IDLE);
    unique case (state)
      dmdp_pkg::S_IDLE: begin
        if (item_take && item.op == dmdp_pkg::OP_ELEMENT) begin
          state_next = dmdp_pkg::S_P1_GO;
        end
      end
      dmdp_pkg::S_P1_GO: begin
        req.start  = 1'b1;
        state_next = dmdp_pkg::S_P1_WAIT;
      end
      dmdp_pkg::S_P1_WAIT: begin
        if (stat.done) begin
          state_next = dmdp_pkg::S_P2_GO;
        end
      end
      dmdp_pkg::S_P2_GO: begin
        req.start  = 1'b1;
        unit_b     = chal_two;
        unit_p     = prime_two;
        state_next = dmdp_pkg::S_P2_WAIT;
      end
      dmdp_pkg::S_P2_WAIT: begin
        if (stat.done) begin
          state_next = row_last ? dmdp_pkg::S_R1_GO : dmdp_pkg::S_IDLE;
        end
      end
      dmdp_pkg::S_R1_GO: begin
        req.start       = 1'b1;
        req.reduce_only = 1'b1;
        unit_a          = sum_one;
        state_next      = dmdp_pkg::S_R1_WAIT;
      end
      dmdp_pkg::S_R1_WAIT: begin
        if (stat.done) begin
          state_next = dmdp_pkg::S_R2_GO;
        end
      end
      dmdp_pkg::S_R2_GO: begin
        req.start       = 1'b1;
        req.reduce_only = 1'b1;
        unit_a          = sum_two;
        unit_p          = prime_two;
        state_next      = dmdp_pkg::S_R2_WAIT;
      end
      dmdp_pkg::S_R2_WAIT: begin
        if (stat.done) begin
          state_next = dmdp_pkg::S_EMIT;
        end
      end
      dmdp_pkg::S_EMIT: begin
        if (emit_now) begin
          state_next = dmdp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dmdp_pkg::S_IDLE;
      end
    endcase
  end

  // Config writes are always taken; the user must keep the block idle then.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_one      <= 64'd2;
      prime_two      <= 64'd2;
      columns_in_use <= dmdp_pkg::COLS_W'(1024);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        dmdp_pkg::REG_PRIME_ONE: prime_one      <= cfg.data;
        dmdp_pkg::REG_PRIME_TWO: prime_two      <= cfg.data;
        dmdp_pkg::REG_COLUMNS:   columns_in_use <= cfg.data[dmdp_pkg::COLS_W-1:0];
        default: begin
          // Inverse registers and unused indexes have no effect.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.op == dmdp_pkg::OP_ELEMENT) begin
      element <= item.word_a;
    end
    if (state == dmdp_pkg::S_R1_WAIT && stat.done) begin
      red_one <= unit_result;
    end
    if (emit_now) begin
      out_row     <= row_counter;
      out_dot_one <= red_one;
      out_dot_two <= unit_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_one        <= '0;
      sum_two        <= '0;
      column_counter <= '0;
      row_counter    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == dmdp_pkg::S_P1_WAIT && stat.done) begin
        sum_one <= sum_one + unit_result;
      end
      if (state == dmdp_pkg::S_P2_WAIT && stat.done) begin
        sum_two <= sum_two + unit_result;
        if (!row_last) begin
          column_counter <= column_counter + 1'b1;
        end
      end
      if (emit_now) begin
        sum_one        <= '0;
        sum_two        <= '0;
        column_counter <= '0;
        row_counter    <= row_counter + 1'b1;
        out_valid      <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.row_number = out_row;
  assign result.dot_one    = out_dot_one;
  assign result.dot_two    = out_dot_two;

  // The unit reports a finished operation only while the sequencer waits.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == dmdp_pkg::S_P1_WAIT || state == dmdp_pkg::S_P2_WAIT ||
                   state == dmdp_pkg::S_R1_WAIT || state == dmdp_pkg::S_R2_WAIT))
    else $error("modular unit finished outside a wait state");

  // An element blocks the input on the following cycle.
  a_element_blocks: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.op == dmdp_pkg::OP_ELEMENT) |=> !item.ready)
    else $error("input ready right after an element");

  // A waiting result is never overwritten by the next row.
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == dmdp_pkg::S_EMIT && result.valid && !result.ready) |=>
      (state == dmdp_pkg::S_EMIT && $stable(result.row_number)))
    else $error("pending result overwritten");

  // The unit is started only when it is free.
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !stat.busy)
    else $error("modular unit started while busy");

endmodule

`default_nettype wire
